FILE: rtl/imn_pkg.sv
// Shared constants, types and result structs for the min/max image normalizer.
package imn_pkg;

    localparam int PIXEL_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_FRAC    = 16;
    localparam int MANT_W      = 32;
    localparam int P_W         = $clog2(MANT_W);
    localparam int LOG_W       = P_W + FRAC_BITS;
    localparam int NORM_STEPS  = $clog2(MANT_W);
    localparam int STEP_W      = $clog2(NORM_STEPS);
    localparam int FCNT_W      = $clog2(FRAC_BITS);
    localparam int DCNT_W      = $clog2(OUT_FRAC);
    localparam int DIV_W       = PIXEL_WIDTH + 1;
    localparam int Q_W         = OUT_FRAC + 1;

    typedef logic signed [PIXEL_WIDTH-1:0] pixel_t;
    typedef logic [LOG_W-1:0]              log_val_t;
    typedef logic [DIV_W-1:0]              div_opd_t;
    typedef logic [Q_W-1:0]                quot_t;

    localparam pixel_t PIX_ZERO = '0;
    localparam quot_t  Q_ONE    = quot_t'(1) << OUT_FRAC;

    typedef struct packed {
        logic     done;
        log_val_t value;
    } log_res_t;

    typedef struct packed {
        logic  done;
        quot_t quot;
    } div_res_t;

endpackage

FILE: rtl/image_minmax_normalizer_top.sv
// Top level of the two-pass min/max image normalizer (linear or log2 scaling).
//
// Input channel in_valid/in_ready carries func, pixel_value (signed Q16.16),
// pixel_missing and frame_start. A scan transfer (func = 0) updates the frame
// minimum and maximum in the cycle it is taken and gives no result. A normalize
// transfer (func = 1) gives one result on out_valid/out_ready: norm_value
// (unsigned Q1.16, 65536 = 1.0) and degenerate.
// A normalize item whose result is not known at once goes, in linear mode, through
// the fractional divider. In log mode the one log2 unit first takes log2(min) and
// log2(max) when they are not cached (a scan clears them), then log2(x), each in
// 5 normalize steps plus 16 squarings, and then the divider runs. in_ready is high
// only while the sequencer is idle, so the next transfer is taken at the earliest in
// the cycle in which the result is first offered; scans go back to back.
// A result waits in the output register while the receiver stalls; the next item
// is still taken, and its result waits until the register is free.
// cfg_wr_en/cfg_wr_data write log_mode; write it only while the block is idle.
// Reset clears log_mode, minimum, maximum and their seen flags, no clearing pass.
module image_minmax_normalizer_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  imn_pkg::pixel_t          pixel_value,
    input  logic                     pixel_missing,
    input  logic                     frame_start,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [imn_pkg::Q_W-1:0]  norm_value,
    output logic                     degenerate,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data
);
    import imn_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LSEL  = 3'd1;
    localparam logic [2:0] S_LWAIT = 3'd2;
    localparam logic [2:0] S_LCHK  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [1:0] T_MIN = 2'd0;
    localparam logic [1:0] T_MAX = 2'd1;
    localparam logic [1:0] T_X   = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  tgt_reg, tgt_next;
    logic        log_mode_reg;
    pixel_t      min_reg, max_reg, x_reg;
    logic        min_seen_reg, max_seen_reg;
    logic        lmin_ok_reg, lmax_ok_reg;
    log_val_t    lmin_reg, lmax_reg, lx_reg;
    quot_t       pend_q_reg, pend_q_next;
    logic        pend_deg_reg, pend_deg_next;
    logic        out_valid_reg;
    quot_t       out_q_reg;
    logic        out_deg_reg;

    logic        in_fire, scan_fire, norm_fire;
    logic        ms, xs, min_upd, max_upd;
    pixel_t      min_cur, max_cur;
    logic        pre_degen;
    pixel_t      x_sel;
    div_opd_t    xe, mine, maxe;

    logic             log_start;
    logic [MANT_W-1:0] log_opd;
    log_res_t         log_res;
    logic             div_start;
    div_opd_t         div_num, div_den;
    div_res_t         div_res;
    logic             out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && !func;
    assign norm_fire = in_fire && func;

    // scan update
    assign ms      = min_seen_reg && !frame_start;
    assign xs      = max_seen_reg && !frame_start;
    assign min_cur = frame_start ? PIX_ZERO : min_reg;
    assign max_cur = frame_start ? PIX_ZERO : max_reg;
    assign min_upd = !pixel_missing && (!log_mode_reg || pixel_value > PIX_ZERO)
                     && (!ms || pixel_value < min_cur);
    assign max_upd = !pixel_missing && (!xs || pixel_value > max_cur);

    // normalize setup
    assign pre_degen = !min_seen_reg || !max_seen_reg
                       || (log_mode_reg && (min_reg <= PIX_ZERO || max_reg <= PIX_ZERO))
                       || (!log_mode_reg && max_reg <= min_reg);
    assign x_sel = (pixel_missing || (log_mode_reg && pixel_value < min_reg))
                   ? min_reg : pixel_value;
    assign xe    = DIV_W'(x_sel);
    assign mine  = DIV_W'(min_reg);
    assign maxe  = DIV_W'(max_reg);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        tgt_next      = tgt_reg;
        pend_q_next   = pend_q_reg;
        pend_deg_next = pend_deg_reg;
        log_start     = 1'b0;
        log_opd       = x_reg;
        div_start     = 1'b0;
        div_num       = xe - mine;
        div_den       = maxe - mine;
        unique case (state_reg)
            S_IDLE:
            begin
                if (norm_fire)
                begin
                    if (pre_degen)
                    begin
                        pend_q_next   = '0;
                        pend_deg_next = 1'b1;
                        state_next    = S_OUT;
                    end
                    else if (log_mode_reg)
                        state_next = S_LSEL;
                    else if (x_sel <= min_reg)
                    begin
                        pend_q_next   = '0;
                        pend_deg_next = 1'b0;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_LSEL:
            begin
                log_start  = 1'b1;
                state_next = S_LWAIT;
                if (!lmin_ok_reg)
                begin
                    log_opd  = min_reg;
                    tgt_next = T_MIN;
                end
                else if (!lmax_ok_reg)
                begin
                    log_opd  = max_reg;
                    tgt_next = T_MAX;
                end
                else
                begin
                    log_opd  = x_reg;
                    tgt_next = T_X;
                end
            end
            S_LWAIT:
            begin
                if (log_res.done)
                    state_next = (tgt_reg == T_X) ? S_LCHK : S_LSEL;
            end
            S_LCHK:
            begin
                if (lmax_reg <= lmin_reg)
                begin
                    pend_q_next   = '0;
                    pend_deg_next = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    div_num    = DIV_W'(lx_reg) - DIV_W'(lmin_reg);
                    div_den    = DIV_W'(lmax_reg) - DIV_W'(lmin_reg);
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    pend_q_next   = div_res.quot;
                    pend_deg_next = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tgt_reg       <= T_MIN;
            log_mode_reg  <= 1'b0;
            min_reg       <= PIX_ZERO;
            max_reg       <= PIX_ZERO;
            min_seen_reg  <= 1'b0;
            max_seen_reg  <= 1'b0;
            lmin_ok_reg   <= 1'b0;
            lmax_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            if (cfg_wr_en)
                log_mode_reg <= cfg_wr_data;
            if (scan_fire)
            begin
                min_reg      <= min_upd ? pixel_value : min_cur;
                max_reg      <= max_upd ? pixel_value : max_cur;
                min_seen_reg <= ms || min_upd;
                max_seen_reg <= xs || max_upd;
                lmin_ok_reg  <= 1'b0;
                lmax_ok_reg  <= 1'b0;
            end
            if (state_reg == S_LWAIT && log_res.done)
            begin
                if (tgt_reg == T_MIN)
                    lmin_ok_reg <= 1'b1;
                if (tgt_reg == T_MAX)
                    lmax_ok_reg <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_q_reg   <= pend_q_next;
        pend_deg_reg <= pend_deg_next;
        if (norm_fire)
            x_reg <= x_sel;
        if (state_reg == S_LWAIT && log_res.done)
        begin
            unique case (tgt_reg)
                T_MIN:   lmin_reg <= log_res.value;
                T_MAX:   lmax_reg <= log_res.value;
                default: lx_reg   <= log_res.value;
            endcase
        end
        if (out_load)
        begin
            out_q_reg   <= pend_q_reg;
            out_deg_reg <= pend_deg_reg;
        end
    end

    imn_log2_unit u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand (log_opd),
        .res     (log_res)
    );

    imn_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    assign out_valid  = out_valid_reg;
    assign norm_value = out_q_reg;
    assign degenerate = out_deg_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> norm_value == '0)
        else $error("degenerate result with nonzero value");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm_value <= Q_ONE)
        else $error("normalized value above 1.0");

    a_log_done: assert property (@(posedge clk) disable iff (!rst_n)
        log_res.done |-> state_reg == S_LWAIT)
        else $error("log2 unit finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_busy_after_norm: assert property (@(posedge clk) disable iff (!rst_n)
        norm_fire |=> !in_ready)
        else $error("ready right after a normalize transfer");

endmodule

FILE: rtl/imn_log2_unit.sv
// Iterative fixed-point log2: binary-search normalize, then one squaring per fraction bit.
module imn_log2_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [imn_pkg::MANT_W-1:0] operand,
    output imn_pkg::log_res_t          res
);
    import imn_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;

    logic [1:0]            phase_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [FCNT_W-1:0]     cnt_reg;
    logic [MANT_W-1:0]     m_reg;
    logic [P_W-1:0]        p_reg;
    logic [FRAC_BITS-1:0]  f_reg;
    logic                  done_reg;

    logic [P_W:0]          amt;
    logic [P_W:0]          sh;
    logic                  top_zero;
    logic [2*MANT_W-1:0]   prod;
    logic [MANT_W:0]       sq;

    assign amt      = (P_W+1)'(MANT_W / 2) >> step_reg;
    assign sh       = (P_W+1)'(MANT_W) - amt;
    assign top_zero = (m_reg >> sh) == '0;
    assign prod     = m_reg * m_reg;
    assign sq       = prod[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                        phase_reg <= PH_NORM;
                end
                PH_NORM:
                begin
                    if (step_reg == STEP_W'(NORM_STEPS - 1))
                        phase_reg <= PH_ITER;
                end
                PH_ITER:
                begin
                    if (cnt_reg == FCNT_W'(FRAC_BITS - 1))
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                    phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            PH_IDLE:
            begin
                m_reg    <= operand;
                p_reg    <= P_W'(MANT_W - 1);
                f_reg    <= '0;
                step_reg <= '0;
                cnt_reg  <= '0;
            end
            PH_NORM:
            begin
                if (top_zero)
                begin
                    m_reg <= m_reg << amt;
                    p_reg <= p_reg - amt[P_W-1:0];
                end
                step_reg <= step_reg + 1'b1;
            end
            PH_ITER:
            begin
                m_reg   <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
                f_reg   <= {f_reg[FRAC_BITS-2:0], sq[MANT_W]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
                m_reg <= m_reg;
        endcase
    end

    assign res.done  = done_reg;
    assign res.value = {p_reg, f_reg};

endmodule

FILE: rtl/imn_frac_div.sv
// Restoring fractional divider, one quotient bit per cycle, result capped at 1.0.
module imn_frac_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  imn_pkg::div_opd_t num,
    input  imn_pkg::div_opd_t den,
    output imn_pkg::div_res_t res
);
    import imn_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_W:0]    rem_reg;
    div_opd_t          den_reg;
    quot_t             q_reg;

    logic [DIV_W:0]    rem2;
    logic              ge;

    assign rem2 = {rem_reg[DIV_W-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    if (num >= den)
                        done_reg <= 1'b1;
                    else
                        busy_reg <= 1'b1;
                end
            end
            else if (cnt_reg == DCNT_W'(OUT_FRAC - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            cnt_reg <= '0;
            q_reg   <= (num >= den) ? Q_ONE : '0;
        end
        else
        begin
            rem_reg <= ge ? (rem2 - {1'b0, den_reg}) : rem2;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;

endmodule
